@@ hw/rtl/lzbd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzbd_pkg
// Shared constants and types of the back-reference and run-length byte
// decoder: history geometry, output lane layout, token codes and the command
// that passes from the parser to the expansion engine.
// ----------------------------------------------------------------------------
package lzbd_pkg;

    localparam int HIST_DEPTH = 1024;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int DIST_W     = 10;
    localparam int OUT_LANES  = 8;
    localparam int LANE_W     = $clog2(OUT_LANES);
    localparam int CNT_W      = 4;
    localparam int LEN_W      = 9;
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_AW     = $clog2(CMD_DEPTH);
    localparam int TDATA_W    = ((OUT_LANES * 8 + CNT_W + 7) / 8) * 8;

    localparam logic [7:0] TOK_LIT_BASE  = 8'h80;
    localparam logic [7:0] TOK_FILL_BASE = 8'hA0;
    localparam logic [7:0] TOK_ZERO_BASE = 8'hE0;
    localparam logic [7:0] TOK_ZERO_LONG = 8'hFF;
    localparam logic [7:0] TOK_LEN_MASK  = 8'h1F;

    typedef struct packed {
        logic              is_copy;
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] back_dist;
        logic [7:0]        value;
    } cmd_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } dbyte_t;

endpackage

@@ hw/rtl/lzbd_front.sv @@
// ----------------------------------------------------------------------------
// lzbd_front
// Token parser. Takes compressed bytes, tracks the parse phase and turns each
// byte that produces output into one copy or run command.
// ----------------------------------------------------------------------------
module lzbd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    input  logic               s_tuser,
    output logic               push_valid,
    output lzbd_pkg::cmd_t     push_cmd,
    input  logic               cmd_full
);

    localparam logic [2:0] PH_TOKEN      = 3'd0;
    localparam logic [2:0] PH_COPY_DIST  = 3'd1;
    localparam logic [2:0] PH_LITERAL    = 3'd2;
    localparam logic [2:0] PH_FILL_VALUE = 3'd3;
    localparam logic [2:0] PH_ZERO_LEN   = 3'd4;

    logic [2:0] phase_reg, phase_next, phase_cur;
    logic [4:0] pend_cnt_reg, pend_cnt_next;
    logic [1:0] pend_dist_reg, pend_dist_next;
    logic [5:0] tok_len_reg, tok_len_next;
    logic       accept;
    logic       emit;
    lzbd_pkg::cmd_t cmd;

    assign s_tready   = !cmd_full;
    assign accept     = s_tvalid && s_tready;
    assign phase_cur  = s_tuser ? PH_TOKEN : phase_reg;
    assign push_valid = accept && emit;
    assign push_cmd   = cmd;

    always_comb begin
        phase_next     = phase_reg;
        pend_cnt_next  = pend_cnt_reg;
        pend_dist_next = pend_dist_reg;
        tok_len_next   = tok_len_reg;
        emit           = 1'b0;
        cmd.is_copy    = 1'b0;
        cmd.len        = lzbd_pkg::LEN_W'(1);
        cmd.back_dist  = {pend_dist_reg, s_tdata};
        cmd.value      = s_tdata;
        unique case (phase_cur)
            PH_COPY_DIST: begin
                emit        = 1'b1;
                cmd.is_copy = 1'b1;
                cmd.len     = lzbd_pkg::LEN_W'(tok_len_reg);
                phase_next  = PH_TOKEN;
            end
            PH_LITERAL: begin
                emit          = 1'b1;
                pend_cnt_next = pend_cnt_reg - 5'd1;
                if (pend_cnt_reg == 5'd1) begin
                    phase_next = PH_TOKEN;
                end
            end
            PH_FILL_VALUE: begin
                emit       = 1'b1;
                cmd.len    = lzbd_pkg::LEN_W'(tok_len_reg);
                phase_next = PH_TOKEN;
            end
            PH_ZERO_LEN: begin
                emit       = 1'b1;
                cmd.len    = lzbd_pkg::LEN_W'(s_tdata) + lzbd_pkg::LEN_W'(2);
                cmd.value  = 8'h00;
                phase_next = PH_TOKEN;
            end
            PH_TOKEN: begin
                pend_cnt_next  = 5'd0;
                pend_dist_next = 2'd0;
                tok_len_next   = 6'd0;
                if (s_tdata < lzbd_pkg::TOK_LIT_BASE) begin
                    pend_dist_next = s_tdata[1:0];
                    tok_len_next   = 6'(s_tdata[6:2]) + 6'd2;
                    phase_next     = PH_COPY_DIST;
                end else if (s_tdata < lzbd_pkg::TOK_FILL_BASE) begin
                    pend_cnt_next = s_tdata[4:0];
                    phase_next    = (s_tdata[4:0] != 5'd0) ? PH_LITERAL : PH_TOKEN;
                end else if (s_tdata < lzbd_pkg::TOK_ZERO_BASE) begin
                    tok_len_next = 6'(s_tdata & lzbd_pkg::TOK_LEN_MASK) + 6'd2;
                    phase_next   = PH_FILL_VALUE;
                end else if (s_tdata != lzbd_pkg::TOK_ZERO_LONG) begin
                    emit       = 1'b1;
                    cmd.len    = lzbd_pkg::LEN_W'(s_tdata & lzbd_pkg::TOK_LEN_MASK)
                                 + lzbd_pkg::LEN_W'(2);
                    cmd.value  = 8'h00;
                    phase_next = PH_TOKEN;
                end else begin
                    phase_next = PH_ZERO_LEN;
                end
            end
            default: begin
                phase_next = PH_TOKEN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TOKEN;
            pend_cnt_reg  <= 5'd0;
            pend_dist_reg <= 2'd0;
            tok_len_reg   <= 6'd0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            pend_cnt_reg  <= pend_cnt_next;
            pend_dist_reg <= pend_dist_next;
            tok_len_reg   <= tok_len_next;
        end
    end

endmodule

@@ hw/rtl/lzbd_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// lzbd_cmd_fifo
// Short command queue between the parser and the expansion engine, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module lzbd_cmd_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  lzbd_pkg::cmd_t     push_cmd,
    output logic               full,
    output logic               pop_valid,
    output lzbd_pkg::cmd_t     pop_cmd,
    input  logic               pop
);

    lzbd_pkg::cmd_t                entry_reg [lzbd_pkg::CMD_DEPTH];
    logic [lzbd_pkg::CMD_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [lzbd_pkg::CMD_AW:0]     count_reg;
    logic                          do_push, do_pop;

    assign full      = count_reg == (lzbd_pkg::CMD_AW + 1)'(lzbd_pkg::CMD_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/lzbd_back.sv @@
// ----------------------------------------------------------------------------
// lzbd_back
// Expansion engine. Carries out one command at a time, one decoded byte per
// cycle while the output is accepted, reading back-references from the history
// memory and writing every decoded byte into it.
// ----------------------------------------------------------------------------
module lzbd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  lzbd_pkg::cmd_t     cmd,
    output logic               cmd_pop,
    output logic               byte_valid,
    output lzbd_pkg::dbyte_t   byte_out,
    input  logic               byte_ready
);

    logic [7:0]                     hist_mem [lzbd_pkg::HIST_DEPTH];

    logic                           act_reg;
    logic [lzbd_pkg::LEN_W-1:0]     rem_reg;
    logic                           copy_reg;
    logic [7:0]                     val_reg;
    logic [lzbd_pkg::HIST_AW-1:0]   dist_reg;
    logic [lzbd_pkg::HIST_AW-1:0]   issue_pos_reg;
    logic                           wrap_reg;

    logic                           p1_v_reg;
    logic                           p1_copy_reg;
    logic [7:0]                     p1_val_reg;
    logic [lzbd_pkg::HIST_AW-1:0]   p1_addr_reg;
    logic                           p1_last_reg;
    logic                           p1_srcok_reg;
    logic [7:0]                     rd_data_reg;

    logic                           p0_fire, p0_last, p1_fire;
    logic [lzbd_pkg::HIST_AW-1:0]   raddr;
    logic                           src_ok, bypass;
    logic [7:0]                     p1_byte;

    always_comb begin
        p1_byte  = p1_copy_reg ? (p1_srcok_reg ? rd_data_reg : 8'h00) : p1_val_reg;
        p1_fire  = p1_v_reg && byte_ready;
        p0_fire  = act_reg && (!p1_v_reg || p1_fire);
        p0_last  = rem_reg == lzbd_pkg::LEN_W'(1);
        cmd_pop  = cmd_valid && (!act_reg || (p0_fire && p0_last));
        raddr    = issue_pos_reg - dist_reg;
        bypass   = p1_v_reg && (p1_addr_reg == raddr);
        src_ok   = wrap_reg || (raddr < issue_pos_reg) || bypass;
    end

    assign byte_valid    = p1_v_reg;
    assign byte_out.data = p1_byte;
    assign byte_out.last = p1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= 1'b0;
            rem_reg       <= '0;
            issue_pos_reg <= '0;
            wrap_reg      <= 1'b0;
            p1_v_reg      <= 1'b0;
        end else begin
            if (cmd_pop) begin
                act_reg <= 1'b1;
                rem_reg <= cmd.len;
            end else if (p0_fire) begin
                act_reg <= !p0_last;
                rem_reg <= rem_reg - 1'b1;
            end
            if (p0_fire) begin
                issue_pos_reg <= issue_pos_reg + 1'b1;
                if (issue_pos_reg == lzbd_pkg::HIST_AW'(lzbd_pkg::HIST_DEPTH - 1)) begin
                    wrap_reg <= 1'b1;
                end
                p1_v_reg <= 1'b1;
            end else if (p1_fire) begin
                p1_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            copy_reg <= cmd.is_copy;
            val_reg  <= cmd.value;
            dist_reg <= lzbd_pkg::HIST_AW'(cmd.back_dist);
        end
        if (p0_fire) begin
            p1_copy_reg  <= copy_reg;
            p1_val_reg   <= val_reg;
            p1_addr_reg  <= issue_pos_reg;
            p1_last_reg  <= p0_last;
            p1_srcok_reg <= src_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_fire) begin
            hist_mem[p1_addr_reg] <= p1_byte;
        end
        if (p0_fire) begin
            rd_data_reg <= bypass ? p1_byte : hist_mem[raddr];
        end
    end

endmodule

@@ hw/rtl/lzbd_pack.sv @@
// ----------------------------------------------------------------------------
// lzbd_pack
// Output packer. Gathers decoded bytes into lanes and hands out a result when
// all lanes are filled or the command that caused them ends.
// ----------------------------------------------------------------------------
module lzbd_pack (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           byte_valid,
    input  lzbd_pkg::dbyte_t               byte_in,
    output logic                           byte_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte0 .. out_byte7 (8 bits each), valid_count (4 bits), zero fill
    output logic [lzbd_pkg::TDATA_W-1:0]   m_tdata,
    output logic                           m_tlast
);

    logic [7:0]                   lane_reg [lzbd_pkg::OUT_LANES];
    logic [lzbd_pkg::LANE_W-1:0]  cnt_reg;
    logic [7:0]                   out_lane_reg [lzbd_pkg::OUT_LANES];
    logic [lzbd_pkg::CNT_W-1:0]   out_cnt_reg;
    logic                         out_last_reg;
    logic                         m_tvalid_reg;

    logic                         in_fire, complete;
    logic [lzbd_pkg::CNT_W-1:0]   cnt_inc;

    assign byte_ready = !m_tvalid_reg || m_tready;
    assign in_fire    = byte_valid && byte_ready;
    assign cnt_inc    = lzbd_pkg::CNT_W'(cnt_reg) + 1'b1;
    assign complete   = byte_in.last ||
                        (cnt_inc == lzbd_pkg::CNT_W'(lzbd_pkg::OUT_LANES));
    assign m_tvalid   = m_tvalid_reg;
    assign m_tlast    = out_last_reg;

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < lzbd_pkg::OUT_LANES; i++) begin
            m_tdata[i*8 +: 8] = out_lane_reg[i];
        end
        m_tdata[lzbd_pkg::OUT_LANES*8 +: lzbd_pkg::CNT_W] = out_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < lzbd_pkg::OUT_LANES; i++) begin
                lane_reg[i] <= 8'h00;
            end
        end else begin
            if (in_fire && complete) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (in_fire) begin
                if (complete) begin
                    cnt_reg <= '0;
                    for (int i = 0; i < lzbd_pkg::OUT_LANES; i++) begin
                        lane_reg[i] <= 8'h00;
                    end
                end else begin
                    cnt_reg <= lzbd_pkg::LANE_W'(cnt_inc);
                    for (int i = 0; i < lzbd_pkg::OUT_LANES; i++) begin
                        if (lzbd_pkg::LANE_W'(i) == cnt_reg) begin
                            lane_reg[i] <= byte_in.data;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && complete) begin
            out_cnt_reg  <= cnt_inc;
            out_last_reg <= byte_in.last;
            for (int i = 0; i < lzbd_pkg::OUT_LANES; i++) begin
                out_lane_reg[i] <= (lzbd_pkg::LANE_W'(i) == cnt_reg) ? byte_in.data
                                                                     : lane_reg[i];
            end
        end
    end

endmodule

@@ hw/rtl/lz_backref_rle_byte_decoder.sv @@
// ----------------------------------------------------------------------------
// With the engine idle, an accepted input item's command passes the command
// queue, the engine and the packer output register before a result is offered.
// Throughput: one input item per cycle while the command queue has room; decoded
// bytes are produced at one per cycle while the packer accepts them; the
// history has one write port. An item that decodes to n bytes holds the engine
// until all n are issued. Reset: parse state and queues clear at once; history
// reads as zeros until written, tracked by the write position: no clearing pass.
// ----------------------------------------------------------------------------
// lz_backref_rle_byte_decoder
// Decoder for an LZ77 scheme with run-length tokens, one compressed byte per
// item in, up to eight decoded bytes per result item out.
// ----------------------------------------------------------------------------
module lz_backref_rle_byte_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // comp_byte (8 bits)
    input  logic [7:0]                     s_tdata,
    // stream_start (1 bit)
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_byte0 .. out_byte7 (8 bits each), valid_count (4 bits), zero fill
    output logic [lzbd_pkg::TDATA_W-1:0]   m_tdata,
    output logic                           m_tlast
);

    logic               push_valid, cmd_full;
    lzbd_pkg::cmd_t     push_cmd, pop_cmd;
    logic               pop_valid, pop;
    logic               byte_valid, byte_ready;
    lzbd_pkg::dbyte_t   dbyte;

    lzbd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .cmd_full   (cmd_full)
    );

    lzbd_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (cmd_full),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop        (pop)
    );

    lzbd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (pop_valid),
        .cmd        (pop_cmd),
        .cmd_pop    (pop),
        .byte_valid (byte_valid),
        .byte_out   (dbyte),
        .byte_ready (byte_ready)
    );

    lzbd_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_in    (dbyte),
        .byte_ready (byte_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
